// ===== sv/frp_pkg.sv =====
package frp_pkg;

  // Default sizes
  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // Gap that every history entry reads as until the history pointer first wraps
  localparam logic [15:0] DEFAULT_GAP_US = 16'd16666;

  // Register reset values
  localparam logic [15:0] REJECT_LOW_RST    = 16'd1000;
  localparam logic [15:0] REJECT_HIGH_RST   = 16'd50000;
  localparam logic [11:0] NUDGE_RST         = 12'd150;
  localparam logic [15:0] GAP_FLOOR_RST     = 16'd6250;
  localparam logic [15:0] GAP_CEILING_RST   = 16'd33300;
  localparam logic [19:0] STARVE_SLACK_RST  = 20'd20000;

  // Register indexes
  localparam int          CFG_IDX_W = 3;
  localparam int          CFG_DAT_W = 20;
  localparam logic [2:0]  CFG_REJECT_LOW   = 3'd0;
  localparam logic [2:0]  CFG_REJECT_HIGH  = 3'd1;
  localparam logic [2:0]  CFG_NUDGE        = 3'd2;
  localparam logic [2:0]  CFG_GAP_FLOOR    = 3'd3;
  localparam logic [2:0]  CFG_GAP_CEILING  = 3'd4;
  localparam logic [2:0]  CFG_STARVE_SLACK = 3'd5;

  // Command codes on the input channel
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic {
    KIND_ARRIVE,
    KIND_TICK
  } kind_t;

  typedef enum logic [2:0] {
    ST_NOTHING      = 3'd0,
    ST_QUEUED       = 3'd1,
    ST_HELD_PENDING = 3'd2,
    ST_REFUSED      = 3'd3,
    ST_RELEASED     = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0] reject_low_us;
    logic [15:0] reject_high_us;
    logic [11:0] nudge_us;
    logic [15:0] gap_floor_us;
    logic [15:0] gap_ceiling_us;
    logic [19:0] starve_slack_us;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] now_us;
    logic [15:0] frame_handle;
    logic [2:0]  sync_interval;
    logic [31:0] present_flags;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_handle;
    logic [2:0]  out_sync_interval;
    logic [31:0] out_flags;
    logic [2:0]  queue_level;
    logic [15:0] average_gap_us;
    logic [15:0] delivery_gap_us;
  } out_item_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [2:0]  sync;
    logic [31:0] flags;
  } frame_t;

  // Classified transaction as handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [31:0] now_us;
    frame_t      frame;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } work_t;

endpackage

// ===== sv/frp_ram.sv =====
module frp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/frp_cfg.sv =====
module frp_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [frp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frp_pkg::CFG_DAT_W-1:0]  cfg_data,
  output frp_pkg::cfg_t                  cfg
);

  frp_pkg::cfg_t cfg_next;

  // Register decode
  always_comb begin
    cfg_next = cfg;
    if (cfg_write) begin
      unique case (cfg_index)
        frp_pkg::CFG_REJECT_LOW:   cfg_next.reject_low_us   = cfg_data[15:0];
        frp_pkg::CFG_REJECT_HIGH:  cfg_next.reject_high_us  = cfg_data[15:0];
        frp_pkg::CFG_NUDGE:        cfg_next.nudge_us        = cfg_data[11:0];
        frp_pkg::CFG_GAP_FLOOR:    cfg_next.gap_floor_us    = cfg_data[15:0];
        frp_pkg::CFG_GAP_CEILING:  cfg_next.gap_ceiling_us  = cfg_data[15:0];
        frp_pkg::CFG_STARVE_SLACK: cfg_next.starve_slack_us = cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reject_low_us   <= frp_pkg::REJECT_LOW_RST;
      cfg.reject_high_us  <= frp_pkg::REJECT_HIGH_RST;
      cfg.nudge_us        <= frp_pkg::NUDGE_RST;
      cfg.gap_floor_us    <= frp_pkg::GAP_FLOOR_RST;
      cfg.gap_ceiling_us  <= frp_pkg::GAP_CEILING_RST;
      cfg.starve_slack_us <= frp_pkg::STARVE_SLACK_RST;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// ===== sv/frp_front.sv =====
module frp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  frp_pkg::in_item_t in_data,
  output frp_pkg::work_t    work,
  input  logic              take
);

  frp_pkg::item_t q [2];
  frp_pkg::item_t cls;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;
  logic           push;

  assign in_ready = (cnt != 2'd2);
  assign push     = in_valid && in_ready;

  // Classify the incoming transaction
  always_comb begin
    cls.now_us       = in_data.now_us;
    cls.frame.handle = in_data.frame_handle;
    cls.frame.sync   = in_data.sync_interval;
    cls.frame.flags  = in_data.present_flags;
    unique case (in_data.cmd)
      frp_pkg::CMD_ARRIVE: cls.kind = frp_pkg::KIND_ARRIVE;
      frp_pkg::CMD_TICK:   cls.kind = frp_pkg::KIND_TICK;
    endcase
  end

  assign work.valid = (cnt != 2'd0);
  assign work.item  = q[rd_ptr];

  // Two-entry queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, take})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== sv/frp_back.sv =====
module frp_back #(
  parameter int HISTORY_DEPTH = frp_pkg::HISTORY_DEPTH_DEF,
  parameter int QUEUE_DEPTH   = frp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  frp_pkg::cfg_t      cfg,
  input  frp_pkg::work_t     work,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output frp_pkg::out_item_t out_data
);

  localparam int HPW   = $clog2(HISTORY_DEPTH);
  localparam int TOTW  = 16 + HPW;
  localparam int QPW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
  // Exact divide by HISTORY_DEPTH through a reciprocal
  localparam int SHIFT = TOTW + HPW;
  localparam int RW    = TOTW + 2;
  localparam int PRODW = TOTW + RW;
  localparam int unsigned RECIP_INT =
    ((32'd1 << SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
  localparam logic [RW-1:0]   RECIP     = RW'(RECIP_INT);
  localparam logic [TOTW-1:0] TOTAL_RST = TOTW'(16666 * HISTORY_DEPTH);
  localparam logic [HPW-1:0]  HPTR_LAST = HPW'(HISTORY_DEPTH - 1);
  localparam logic [QPW-1:0]  QPTR_LAST = QPW'(QUEUE_DEPTH - 1);
  localparam logic [QCW-1:0]  QCNT_FULL = QCW'(QUEUE_DEPTH);

  // Architectural state
  logic [HPW-1:0]   hist_ptr, hist_ptr_next;
  logic             hist_wrapped, hist_wrapped_next;
  logic [TOTW-1:0]  total, total_next;
  logic [15:0]      avg;
  logic [31:0]      last_return, last_return_next;
  logic             return_seen, return_seen_next;
  logic [31:0]      last_release, last_release_next;
  logic             release_seen, release_seen_next;
  frp_pkg::frame_t  fifo [QUEUE_DEPTH];
  logic [QPW-1:0]   head, head_next;
  logic [QCW-1:0]   count, count_next;
  logic             pending_valid, pending_valid_next;
  frp_pkg::frame_t  pending, pending_next;
  logic             held_valid, held_valid_next;
  frp_pkg::frame_t  held, held_next;
  logic [31:0]      held_target, held_target_next;
  logic [15:0]      last_gap, last_gap_next;
  logic             out_valid_next;

  // Step datapath
  logic                  fire;
  logic [31:0]           now;
  logic [31:0]           gap;
  logic                  gap_ok;
  logic [15:0]           hist_rdata;
  logic [15:0]           hist_old;
  logic                  hist_we;
  logic [TOTW-1:0]       total_upd;
  logic [PRODW-1:0]      prod;
  logic [15:0]           avg_calc;
  logic                  rel_due;
  logic [31:0]           since_target;
  logic                  held_left;
  logic                  pop;
  logic [QCW-1:0]        count_pop;
  logic [QPW-1:0]        head_inc;
  logic signed [17:0]    g_raw;
  logic signed [17:0]    g_floor;
  logic signed [17:0]    g_clamp;
  logic [15:0]           gap_out;
  logic [31:0]           base_release;
  logic [31:0]           tgt_plain;
  logic [31:0]           late;
  logic                  snap;
  logic                  push_en;
  logic [QPW-1:0]        push_head;
  logic [QCW-1:0]        push_cnt;
  logic [QPW:0]          push_sum;
  logic [QPW-1:0]        push_slot;
  frp_pkg::frame_t       push_frame;
  frp_pkg::status_t      status;
  frp_pkg::frame_t       rel;
  frp_pkg::out_item_t    out_next;

  assign fire = work.valid && (!out_valid || out_ready);
  assign take = fire;
  assign now  = work.item.now_us;

  // Gap history memory; read address runs one step ahead of the pointer
  frp_ram #(
    .WIDTH (16),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_ptr),
    .wdata (gap[15:0]),
    .raddr (hist_ptr_next),
    .rdata (hist_rdata)
  );

  // Arrival gap measurement; entries past the pointer are unwritten until wrap
  assign gap       = now - last_return;
  assign gap_ok    = return_seen && (gap > 32'(cfg.reject_low_us))
                     && (gap < 32'(cfg.reject_high_us));
  assign hist_old  = hist_wrapped ? hist_rdata : frp_pkg::DEFAULT_GAP_US;
  assign total_upd = total - TOTW'(hist_old) + TOTW'(gap[15:0]);

  // Running average of the updated total
  assign prod     = PRODW'(total_next) * PRODW'(RECIP);
  assign avg_calc = prod[SHIFT +: 16];

  // Release test and pop decision
  assign since_target = now - held_target;
  assign rel_due      = held_valid && !since_target[31];
  assign held_left    = held_valid && !rel_due;
  assign pop          = !held_left && (count != '0);
  assign count_pop    = count - QCW'(1);
  assign head_inc     = (head == QPTR_LAST) ? '0 : head + QPW'(1);

  // Delivery gap: nudge by level after pop, floor then ceiling
  always_comb begin
    g_raw = $signed({2'b00, avg});
    if (32'(count_pop) >= 32'd2) begin
      g_raw = $signed({2'b00, avg}) - $signed({6'b0, cfg.nudge_us});
    end else if (count_pop == '0) begin
      g_raw = $signed({2'b00, avg}) + $signed({6'b0, cfg.nudge_us});
    end
    g_floor = (g_raw < $signed({2'b00, cfg.gap_floor_us}))
              ? $signed({2'b00, cfg.gap_floor_us}) : g_raw;
    g_clamp = (g_floor > $signed({2'b00, cfg.gap_ceiling_us}))
              ? $signed({2'b00, cfg.gap_ceiling_us}) : g_floor;
  end
  assign gap_out = g_clamp[15:0];

  // Target time, with snap to now when starved
  assign base_release = rel_due ? now : last_release;
  assign tgt_plain    = base_release + {16'b0, gap_out};
  assign late         = now - tgt_plain;
  assign snap         = !late[31] && (late > 32'(cfg.starve_slack_us));

  // Step control and next state
  always_comb begin
    hist_ptr_next      = hist_ptr;
    hist_wrapped_next  = hist_wrapped;
    hist_we            = 1'b0;
    total_next         = total;
    last_return_next   = last_return;
    return_seen_next   = return_seen;
    last_release_next  = last_release;
    release_seen_next  = release_seen;
    head_next          = head;
    count_next         = count;
    pending_valid_next = pending_valid;
    pending_next       = pending;
    held_valid_next    = held_valid;
    held_next          = held;
    held_target_next   = held_target;
    last_gap_next      = last_gap;
    push_en            = 1'b0;
    push_head          = head;
    push_cnt           = count;
    push_frame         = work.item.frame;
    status             = frp_pkg::ST_NOTHING;
    rel                = '0;
    out_valid_next     = out_valid && !out_ready;

    if (fire) begin
      out_valid_next = 1'b1;
      unique case (work.item.kind)
        frp_pkg::KIND_ARRIVE: begin
          if (pending_valid) begin
            status = frp_pkg::ST_REFUSED;
          end else begin
            if (gap_ok) begin
              hist_we    = 1'b1;
              total_next = total_upd;
              if (hist_ptr == HPTR_LAST) begin
                hist_ptr_next     = '0;
                hist_wrapped_next = 1'b1;
              end else begin
                hist_ptr_next = hist_ptr + HPW'(1);
              end
            end
            if (count < QCNT_FULL) begin
              push_en          = 1'b1;
              count_next       = count + QCW'(1);
              last_return_next = now;
              return_seen_next = 1'b1;
              status           = frp_pkg::ST_QUEUED;
            end else begin
              pending_valid_next = 1'b1;
              pending_next       = work.item.frame;
              status             = frp_pkg::ST_HELD_PENDING;
            end
          end
        end
        frp_pkg::KIND_TICK: begin
          if (rel_due) begin
            status            = frp_pkg::ST_RELEASED;
            rel               = held;
            held_valid_next   = 1'b0;
            last_release_next = now;
            release_seen_next = 1'b1;
          end
          if (pop) begin
            held_valid_next = 1'b1;
            held_next       = fifo[head];
            head_next       = head_inc;
            count_next      = count_pop;
            last_gap_next   = gap_out;
            if (release_seen || rel_due) begin
              held_target_next = snap ? now : tgt_plain;
            end else begin
              held_target_next = now;
            end
            // Pending frame moves into the slot freed by the pop
            if (pending_valid) begin
              push_en            = 1'b1;
              push_head          = head_inc;
              push_cnt           = count_pop;
              push_frame         = pending;
              count_next         = count;
              last_return_next   = now;
              return_seen_next   = 1'b1;
              pending_valid_next = 1'b0;
            end
          end
        end
      endcase
    end
  end

  // Tail slot of the frame queue
  assign push_sum  = {1'b0, push_head} + (QPW + 1)'(push_cnt);
  assign push_slot = (push_sum >= (QPW + 1)'(QUEUE_DEPTH))
                     ? QPW'(push_sum - (QPW + 1)'(QUEUE_DEPTH)) : push_sum[QPW-1:0];

  // Result of this step
  assign out_next.status            = status;
  assign out_next.out_handle        = rel.handle;
  assign out_next.out_sync_interval = rel.sync;
  assign out_next.out_flags         = rel.flags;
  assign out_next.queue_level       = 3'(count_next);
  assign out_next.average_gap_us    = avg_calc;
  assign out_next.delivery_gap_us   = last_gap_next;

  // Payload storage
  always_ff @(posedge clk) begin
    if (push_en) begin
      fifo[push_slot] <= push_frame;
    end
    pending <= pending_next;
    held    <= held_next;
    if (fire) begin
      out_data <= out_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_ptr      <= '0;
      hist_wrapped  <= 1'b0;
      total         <= TOTAL_RST;
      avg           <= frp_pkg::DEFAULT_GAP_US;
      last_return   <= '0;
      return_seen   <= 1'b0;
      last_release  <= '0;
      release_seen  <= 1'b0;
      head          <= '0;
      count         <= '0;
      pending_valid <= 1'b0;
      held_valid    <= 1'b0;
      held_target   <= '0;
      last_gap      <= '0;
      out_valid     <= 1'b0;
    end else begin
      hist_ptr      <= hist_ptr_next;
      hist_wrapped  <= hist_wrapped_next;
      total         <= total_next;
      avg           <= avg_calc;
      last_return   <= last_return_next;
      return_seen   <= return_seen_next;
      last_release  <= last_release_next;
      release_seen  <= release_seen_next;
      head          <= head_next;
      count         <= count_next;
      pending_valid <= pending_valid_next;
      held_valid    <= held_valid_next;
      held_target   <= held_target_next;
      last_gap      <= last_gap_next;
      out_valid     <= out_valid_next;
    end
  end

endmodule

// ===== sv/frame_release_pacer.sv =====
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_ready    in_data   (frp_pkg::in_item_t)
// out       out  out_valid / out_ready  out_data  (frp_pkg::out_item_t)
// cfg       in   cfg_write              cfg_index, cfg_data
//
// One transaction per cycle sustained while the output is not stalled; each
// result is registered after the two-entry input queue and the step unit.
// The step unit does all state updates of one transaction at once; the
// moving average is held in a registered reciprocal multiply of the total.
// Synchronous reset, no clearing pass; history entries read as the default
// gap until the pointer first wraps. Output stalls back up into the input
// queue; in_ready drops only when both queue entries are occupied.
module frame_release_pacer #(
  parameter int HISTORY_DEPTH = frp_pkg::HISTORY_DEPTH_DEF,
  parameter int QUEUE_DEPTH   = frp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  frp_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output frp_pkg::out_item_t            out_data,
  input  logic                          cfg_write,
  input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frp_pkg::CFG_DAT_W-1:0] cfg_data
);

  frp_pkg::cfg_t  cfg;
  frp_pkg::work_t work;
  logic           take;

  frp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  frp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .work     (work),
    .take     (take)
  );

  frp_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .work      (work),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/frp_checker.sv =====
module frp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input frp_pkg::out_item_t out_data
);

  // Both sides come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pacer not empty after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Frame fields are only carried on a release
  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != frp_pkg::ST_RELEASED) |->
      (out_data.out_handle == '0) && (out_data.out_sync_interval == '0)
      && (out_data.out_flags == '0))
    else $error("frame fields set without a release");

endmodule

bind frame_release_pacer frp_checker u_frp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 110;

  // Expected-result tracker: mirrors the pacer state and queues one result per item
  class pacer_scoreboard;
    frp_pkg::cfg_t      cfg;
    int unsigned        gap_hist [frp_pkg::HISTORY_DEPTH_DEF];
    int unsigned        hist_ptr;
    int unsigned        hist_sum;
    bit [31:0]          last_return;
    bit [31:0]          last_release;
    bit [31:0]          held_target;
    bit                 return_seen;
    bit                 release_seen;
    frp_pkg::frame_t    fifo [frp_pkg::QUEUE_DEPTH_DEF];
    int unsigned        fifo_head;
    int unsigned        fifo_count;
    bit                 pend_valid;
    frp_pkg::frame_t    pend_frame;
    bit                 held_valid;
    frp_pkg::frame_t    held_frame;
    bit [15:0]          last_gap;
    frp_pkg::out_item_t expected_results [$];
    int                 errors;

    function new();
      cfg = '{reject_low_us: frp_pkg::REJECT_LOW_RST,
              reject_high_us: frp_pkg::REJECT_HIGH_RST,
              nudge_us: frp_pkg::NUDGE_RST, gap_floor_us: frp_pkg::GAP_FLOOR_RST,
              gap_ceiling_us: frp_pkg::GAP_CEILING_RST,
              starve_slack_us: frp_pkg::STARVE_SLACK_RST};
      foreach (gap_hist[i]) gap_hist[i] = frp_pkg::DEFAULT_GAP_US;
      hist_sum = frp_pkg::DEFAULT_GAP_US * frp_pkg::HISTORY_DEPTH_DEF;
      hist_ptr = 0;
      last_return = '0;
      last_release = '0;
      held_target = '0;
      last_gap = '0;
      fifo_head = 0;
      fifo_count = 0;
      errors = 0;
    endfunction

    function bit [15:0] average();
      return 16'(hist_sum / frp_pkg::HISTORY_DEPTH_DEF);
    endfunction

    // a frame entering the FIFO also marks the arrival time for the next gap
    function void enqueue_frame(frp_pkg::frame_t f, bit [31:0] now);
      fifo[(fifo_head + fifo_count) % frp_pkg::QUEUE_DEPTH_DEF] = f;
      fifo_count++;
      last_return = now;
      return_seen = 1'b1;
    endfunction

    function void note_accepted(frp_pkg::in_item_t it);
      frp_pkg::out_item_t r;
      frp_pkg::frame_t    f;
      bit [31:0]          gap;
      bit [31:0]          tgt;
      bit [31:0]          late;
      int                 g;
      r = '0;
      if (it.cmd == frp_pkg::CMD_ARRIVE) begin
        f.handle = it.frame_handle;
        f.sync = it.sync_interval;
        f.flags = it.present_flags;
        if (pend_valid) begin
          r.status = frp_pkg::ST_REFUSED;
        end else begin
          // gap feeds the average only strictly inside the reject window
          if (return_seen) begin
            gap = it.now_us - last_return;
            if (gap > cfg.reject_low_us && gap < cfg.reject_high_us) begin
              hist_sum = hist_sum - gap_hist[hist_ptr] + gap;
              gap_hist[hist_ptr] = gap;
              hist_ptr = (hist_ptr + 1) % frp_pkg::HISTORY_DEPTH_DEF;
            end
          end
          if (fifo_count < frp_pkg::QUEUE_DEPTH_DEF) begin
            enqueue_frame(f, it.now_us);
            r.status = frp_pkg::ST_QUEUED;
          end else begin
            pend_frame = f;
            pend_valid = 1'b1;
            r.status = frp_pkg::ST_HELD_PENDING;
          end
        end
      end else begin
        // release once the target is reached (wrap-safe compare)
        tgt = it.now_us - held_target;
        if (held_valid && !tgt[31]) begin
          r.status = frp_pkg::ST_RELEASED;
          r.out_handle = held_frame.handle;
          r.out_sync_interval = held_frame.sync;
          r.out_flags = held_frame.flags;
          held_valid = 1'b0;
          last_release = it.now_us;
          release_seen = 1'b1;
        end
        // pop next frame, nudge by level, floor then ceiling
        if (!held_valid && fifo_count > 0) begin
          held_frame = fifo[fifo_head];
          held_valid = 1'b1;
          fifo_head = (fifo_head + 1) % frp_pkg::QUEUE_DEPTH_DEF;
          fifo_count--;
          g = int'(average());
          if (fifo_count >= 2) g -= int'(cfg.nudge_us);
          else if (fifo_count == 0) g += int'(cfg.nudge_us);
          if (g < int'(cfg.gap_floor_us)) g = int'(cfg.gap_floor_us);
          if (g > int'(cfg.gap_ceiling_us)) g = int'(cfg.gap_ceiling_us);
          last_gap = g[15:0];
          // first pop or starved: target snaps to now
          held_target = it.now_us;
          if (release_seen) begin
            tgt = last_release + last_gap;
            late = it.now_us - tgt;
            if (late[31] || late <= cfg.starve_slack_us) held_target = tgt;
          end
          if (pend_valid) begin
            enqueue_frame(pend_frame, it.now_us);
            pend_valid = 1'b0;
          end
        end
      end
      r.queue_level = 3'(fifo_count);
      r.average_gap_us = average();
      r.delivery_gap_us = last_gap;
      expected_results.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(frp_pkg::out_item_t got);
      frp_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual 0x%0h", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare("status", 32'(want.status), 32'(got.status));
      compare("out_handle", 32'(want.out_handle), 32'(got.out_handle));
      compare("out_sync_interval", 32'(want.out_sync_interval),
              32'(got.out_sync_interval));
      compare("out_flags", want.out_flags, got.out_flags);
      compare("queue_level", 32'(want.queue_level), 32'(got.queue_level));
      compare("average_gap_us", 32'(want.average_gap_us), 32'(got.average_gap_us));
      compare("delivery_gap_us", 32'(want.delivery_gap_us), 32'(got.delivery_gap_us));
    endfunction
  endclass

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  frp_pkg::in_item_t             in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  frp_pkg::out_item_t            out_data;
  logic                          cfg_write = 1'b0;
  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [frp_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  pacer_scoreboard sb;
  bit              calm = 1'b0;
  logic [31:0]     wall_us;

  frame_release_pacer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // idle cycles before the next transaction; none during calm stretches
  function automatic int pause_len();
    return calm ? 0 : int'($urandom_range(0, 3));
  endfunction

  task automatic send_item(input frp_pkg::in_item_t it);
    int n;
    n = pause_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_accepted(it);
  endtask

  task automatic send_arrive(input logic [31:0] now, input logic [15:0] handle,
                             input logic [2:0] sync, input logic [31:0] flags);
    frp_pkg::in_item_t it;
    it.cmd = frp_pkg::CMD_ARRIVE;
    it.now_us = now;
    it.frame_handle = handle;
    it.sync_interval = sync;
    it.present_flags = flags;
    send_item(it);
  endtask

  // frame fields of a tick are don't-care; fill them with junk
  task automatic send_tick(input logic [31:0] now);
    frp_pkg::in_item_t it;
    it.cmd = frp_pkg::CMD_TICK;
    it.now_us = now;
    it.frame_handle = 16'($urandom);
    it.sync_interval = 3'($urandom_range(0, 7));
    it.present_flags = $urandom;
    send_item(it);
  endtask

  // drop valid, drain all results, then a few spare cycles for the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [frp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [frp_pkg::CFG_DAT_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input frp_pkg::cfg_t c);
    write_reg(frp_pkg::CFG_REJECT_LOW, frp_pkg::CFG_DAT_W'(c.reject_low_us));
    write_reg(frp_pkg::CFG_REJECT_HIGH, frp_pkg::CFG_DAT_W'(c.reject_high_us));
    write_reg(frp_pkg::CFG_NUDGE, frp_pkg::CFG_DAT_W'(c.nudge_us));
    write_reg(frp_pkg::CFG_GAP_FLOOR, frp_pkg::CFG_DAT_W'(c.gap_floor_us));
    write_reg(frp_pkg::CFG_GAP_CEILING, frp_pkg::CFG_DAT_W'(c.gap_ceiling_us));
    write_reg(frp_pkg::CFG_STARVE_SLACK, frp_pkg::CFG_DAT_W'(c.starve_slack_us));
    cfg_write <= 1'b0;
    sb.cfg = c;
  endtask

  // mostly paced arrivals and ticks, with bursts, long stalls and raw noise
  task automatic random_traffic(input int count);
    int                done;
    int                r;
    frp_pkg::in_item_t it;
    done = 0;
    wall_us = $urandom;
    while (done < count) begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        it.cmd = 1'($urandom_range(0, 1));
        it.now_us = $urandom;
        it.frame_handle = 16'($urandom);
        it.sync_interval = 3'($urandom_range(0, 7));
        it.present_flags = $urandom;
        send_item(it);
        done++;
      end else if (r < 12) begin
        // burst to overflow the FIFO into the pending slot and refusals
        repeat (5) begin
          wall_us += $urandom_range(0, 3000);
          send_arrive(wall_us, 16'($urandom), 3'($urandom_range(0, 7)), $urandom);
        end
        done += 5;
      end else if (r < 55) begin
        if ($urandom_range(0, 19) == 0) wall_us += $urandom_range(30000, 2000000);
        else wall_us += $urandom_range(0, 9000);
        send_tick(wall_us);
        done++;
      end else begin
        if ($urandom_range(0, 9) == 0) wall_us += $urandom_range(0, 70000);
        else wall_us += $urandom_range(500, 30000);
        send_arrive(wall_us, 16'($urandom), 3'($urandom_range(0, 7)), $urandom);
        done++;
      end
    end
  endtask

  // result side: random stall per transaction, checked on acceptance
  initial begin
    int n;
    wait (rst == 1'b0);
    forever begin
      n = pause_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_data);
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL frame_release_pacer");
    $finish;
  end

  initial begin
    frp_pkg::cfg_t c;
    logic [31:0]   t;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: window edges, full FIFO, pending, refusal, release timing, wrap
    t = 32'hFFFF_8000;
    send_tick(t);
    send_arrive(t, 16'h0000, 3'd0, 32'h0000_0000);
    t += 1000;
    send_arrive(t, 16'hFFFF, 3'd7, 32'hFFFF_FFFF);
    t += 1001;
    send_arrive(t, 16'h1234, 3'd4, 32'hA5A5_A5A5);
    t += 50000;
    send_arrive(t, 16'h5A5A, 3'd5, 32'h5A5A_5A5A);
    t += 49999;
    send_arrive(t, 16'h0F0F, 3'd6, 32'h0F0F_0F0F);
    t += 10;
    send_arrive(t, 16'hF0F0, 3'd1, 32'hF0F0_F0F0);
    send_tick(t);
    send_tick(t);
    send_tick(t + 1);
    t += 100000;
    send_tick(t);
    send_tick(t);
    t += 200;
    send_tick(t);
    t += 17000;
    send_tick(t);
    t += 40000;
    send_tick(t);
    send_tick(t);
    send_arrive(t - 5000, 16'h00FF, 3'd2, 32'h8000_0001);
    settle();

    // random phases under several register settings, extremes first
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: c = '{reject_low_us: 16'h0000, reject_high_us: 16'hFFFF, nudge_us: 12'hFFF,
                 gap_floor_us: 16'h0000, gap_ceiling_us: 16'hFFFF,
                 starve_slack_us: 20'h00000};
        1: c = '{reject_low_us: 16'hFFFF, reject_high_us: 16'h0000, nudge_us: 12'h000,
                 gap_floor_us: 16'hFFFF, gap_ceiling_us: 16'h0000,
                 starve_slack_us: 20'hFFFFF};
        2, 3: c = '{reject_low_us: 16'($urandom_range(0, 8000)),
                    reject_high_us: 16'($urandom_range(8000, 65535)),
                    nudge_us: 12'($urandom_range(0, 4095)),
                    gap_floor_us: 16'($urandom_range(0, 20000)),
                    gap_ceiling_us: 16'($urandom_range(0, 65535)),
                    starve_slack_us: 20'($urandom_range(0, 200000))};
        default: c = '{reject_low_us: frp_pkg::REJECT_LOW_RST,
                       reject_high_us: frp_pkg::REJECT_HIGH_RST,
                       nudge_us: frp_pkg::NUDGE_RST,
                       gap_floor_us: frp_pkg::GAP_FLOOR_RST,
                       gap_ceiling_us: frp_pkg::GAP_CEILING_RST,
                       starve_slack_us: frp_pkg::STARVE_SLACK_RST};
      endcase
      program_regs(c);
      random_traffic(PHASE_ITEMS);
      settle();
    end

    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("PASS frame_release_pacer");
    else
      $display("FAIL frame_release_pacer");
    $finish;
  end

endmodule

// ===== frame_release_pacer.f =====
sv/frp_pkg.sv
sv/frp_ram.sv
sv/frp_cfg.sv
sv/frp_front.sv
sv/frp_back.sv
sv/frame_release_pacer.sv
sv/frp_checker.sv
bench/tb.sv
